// ----- rtl/core/cdsat_pkg.sv -----
// Shared types, codes and constants of the CD image sector address translator.
// No dependencies; the top level, the checker and the testbench import this package.
package cdsat_pkg;

	localparam int MAX_TRACKS_DEF = 99;
	localparam int DIV_BITS = 40;

	localparam logic [11:0] SECTOR_AREA = 12'd2352;
	localparam logic [11:0] SUBCODE_BYTES = 12'd96;
	localparam logic [7:0] FPH_RESET = 8'd8;
	localparam logic [11:0] UNIT_RESET = 12'd2448;
	localparam logic [39:0] MASK40 = 40'hFF_FFFF_FFFF;
	localparam logic [25:0] MASK24 = 26'h0FF_FFFF;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_SEEK = 2'd1,
		MODE_READ = 2'd2,
		MODE_SUBQ = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_END = 2'd1,
		ST_GAP = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_FPH = 2'd0,
		CFG_UNIT = 2'd1,
		CFG_SUBQ = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		KIND_AUDIO = 3'd0,
		KIND_MODE1 = 3'd1,
		KIND_MODE1_RAW = 3'd2,
		KIND_MODE2 = 3'd3,
		KIND_FORM1 = 3'd4,
		KIND_FORM2 = 3'd5,
		KIND_FORM_MIX = 3'd6,
		KIND_MODE2_RAW = 3'd7
	} kind_t;

	typedef struct packed {
		logic [1:0] mode;
		logic first_track;
		logic [2:0] track_kind;
		logic [18:0] frame_count;
		logic [15:0] pregap_frames;
		logic pregap_stored;
		logic [39:0] seek_offset;
		logic [15:0] bytes_wanted;
		logic [23:0] lba;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [23:0] hunk_index;
		logic [19:0] byte_in_hunk;
		logic [11:0] segment_bytes;
		logic zero_fill;
		logic swap_bytes;
		logic fetch_hunk;
		logic [39:0] position;
		logic [39:0] image_size;
	} rsp_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [18:0] frames;
		logic [23:0] lba_start;
		logic [23:0] store_start;
		logic [39:0] virtual_start;
	} entry_t;

	function automatic logic [11:0] sector_of(input logic [2:0] k);
		logic [11:0] r;
		case (kind_t'(k))
			KIND_MODE1, KIND_FORM1: r = 12'd2048;
			KIND_MODE2, KIND_FORM_MIX: r = 12'd2336;
			KIND_FORM2: r = 12'd2324;
			default: r = 12'd2352;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/cdsat_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cdsat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/cd_image_sector_address_translator.sv -----
// Top level of the CD image sector address translator: track table, lookup and divider.
// Depends on cdsat_pkg and cdsat_ram.
//
// Requests enter on in_valid/in_ready with an req_t payload and each gives exactly one
// response on out_valid/out_ready as an rsp_t. One request is worked at a time.
// A load passes S_LOAD_MUL and S_LOAD_FIN, and a seek goes straight to S_DONE. A read segment
// or subchannel lookup scans the track table held in a one-port-read RAM, through
// S_SCAN_RD and S_SCAN_CMP for each entry, then runs a one-bit-per-cycle divider:
// a read uses the shared divider for the sector split and then for the hunk split,
// which a read in a gap skips; a subchannel lookup uses it for the hunk split only.
// The response sits in an output register; a new request is taken while it waits,
// and that request finishes only when the register is free, so a stalled receiver
// holds the block after at most one request more.
// Reset empties the track table, the cursors, the position and the hunk cache, and
// loads the register defaults; no clearing pass is needed. Registers are to be written on
// cfg_we only while the block is idle; the user is bound by this, the block does not enforce it.
module cd_image_sector_address_translator
	import cdsat_pkg::*;
#(
	parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsp_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [11:0] cfg_data
);
	localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CW = $clog2(MAX_TRACKS + 1);
	localparam int DCW = $clog2(DIV_BITS);
	localparam int EW = $bits(entry_t);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_LOAD_MUL = 14'b00000000000010,
		S_LOAD_FIN = 14'b00000000000100,
		S_READ_CHK = 14'b00000000001000,
		S_SUB_CHK = 14'b00000000010000,
		S_SCAN_RD = 14'b00000000100000,
		S_SCAN_CMP = 14'b00000001000000,
		S_SCAN_LAST = 14'b00000010000000,
		S_MATCH = 14'b00000100000000,
		S_DIV_A = 14'b00001000000000,
		S_SEG = 14'b00010000000000,
		S_DIV_B = 14'b00100000000000,
		S_LOC = 14'b01000000000000,
		S_DONE = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic [7:0] fph_q;
	logic [11:0] unit_q;
	logic subq_on_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] idx_q;
	logic [23:0] lc_q;
	logic [23:0] sc_q;
	logic [39:0] total_q;
	logic [39:0] pos_q;
	logic [23:0] ch_q;
	logic cv_q;
	logic [2:0] last_kind_q;
	logic [23:0] last_ts_q;
	logic [39:0] last_vs_q;
	req_t in_q;
	entry_t prev_q;
	logic [39:0] vend_q;
	logic [25:0] ts_s1;
	logic [25:0] next_s1;
	logic [25:0] snext_s1;
	logic [36:0] prodv_s1;
	logic [30:0] prodt_s1;
	logic full_s1;
	logic [39:0] div_q;
	logic [11:0] div_rem_q;
	logic [11:0] div_den_q;
	logic [DCW-1:0] div_cnt_q;
	logic [1:0] st_q;
	logic [15:0] len_q;
	logic [11:0] extra_q;
	logic zf_q;
	logic sw_q;
	logic [23:0] hunk_q;
	logic [19:0] bih_q;
	logic fetch_q;
	rsp_t out_q;
	logic out_valid_q;

	entry_t cur;
	entry_t wentry;
	logic [EW-1:0] ram_rdata;
	logic ram_we;
	logic done_fire;

	logic [25:0] ts_c;
	logic [25:0] next_c;
	logic [19:0] fr_pad;
	logic [25:0] snext_c;
	logic [24:0] dts_c;
	logic [36:0] prodv_c;
	logic [30:0] prodt_c;
	logic [41:0] vs_c;
	logic [41:0] tot_c;
	logic load_ok;

	logic [39:0] bound_rd;
	logic [24:0] bound_sub;
	logic hit;

	logic [12:0] div_t;
	logic div_ge;

	logic [39:0] rel_c;
	logic [23:0] sfidx_c;
	logic [11:0] ds_c;
	logic [11:0] room_c;
	logic [39:0] vleft_c;
	logic [15:0] len1_c;
	logic [15:0] len_c;
	logic [24:0] sf_rd_c;
	logic [24:0] sf_sub_c;
	logic [7:0] fph_eff;
	logic [20:0] bih_c;
	logic [23:0] hunk_c;

	assign cur = entry_t'(ram_rdata);
	assign fph_eff = (fph_q == 8'd0) ? 8'd1 : fph_q;

	assign ts_c = in_q.pregap_stored ? {2'b0, lc_q}
		: ({2'b0, lc_q} + {10'b0, in_q.pregap_frames});
	assign next_c = ts_c + {7'b0, in_q.frame_count};
	assign fr_pad = ({1'b0, in_q.frame_count} + 20'd3) & ~20'd3;
	assign snext_c = {2'b0, sc_q} + {6'b0, fr_pad};
	assign dts_c = ts_c[24:0] - {1'b0, last_ts_q};
	assign prodv_c = (n_q == '0) ? '0 : (37'(dts_c) * 37'(sector_of(last_kind_q)));
	assign prodt_c = 31'(in_q.frame_count) * 31'(sector_of(in_q.track_kind));
	assign vs_c = ((n_q == '0) ? 42'd0 : {2'b0, last_vs_q}) + {5'b0, prodv_s1};
	assign tot_c = vs_c + {11'b0, prodt_s1};
	assign load_ok = !full_s1 && (next_s1 <= MASK24) && (snext_s1 <= MASK24)
		&& (tot_c <= {2'b0, MASK40});

	assign wentry = '{kind: in_q.track_kind, frames: in_q.frame_count,
		lba_start: ts_s1[23:0], store_start: sc_q, virtual_start: vs_c[39:0]};
	assign ram_we = (state_q == S_LOAD_FIN) && load_ok;

	assign bound_rd = (state_q == S_SCAN_LAST) ? total_q : cur.virtual_start;
	assign bound_sub = (state_q == S_SCAN_LAST)
		? ({1'b0, prev_q.lba_start} + {6'b0, prev_q.frames}) : {1'b0, cur.lba_start};

	always_comb begin
		if (in_q.mode == MODE_READ) begin
			hit = (pos_q >= prev_q.virtual_start) && (pos_q < bound_rd);
		end else begin
			hit = (in_q.lba >= prev_q.lba_start) && ({1'b0, in_q.lba} < bound_sub);
		end
	end

	assign div_t = {div_rem_q, div_q[DIV_BITS-1]};
	assign div_ge = div_t >= {1'b0, div_den_q};

	assign rel_c = pos_q - prev_q.virtual_start;
	assign sfidx_c = in_q.lba - prev_q.lba_start;
	assign sf_sub_c = {1'b0, prev_q.store_start} + {1'b0, sfidx_c};
	assign ds_c = sector_of(prev_q.kind);
	assign room_c = ds_c - div_rem_q;
	assign vleft_c = vend_q - pos_q;
	assign len1_c = (in_q.bytes_wanted < {4'b0, room_c}) ? in_q.bytes_wanted
		: {4'b0, room_c};
	assign len_c = ({24'b0, len1_c} < vleft_c) ? len1_c : vleft_c[15:0];
	assign sf_rd_c = {1'b0, prev_q.store_start} + {6'b0, div_q[18:0]};
	assign hunk_c = div_q[23:0];
	assign bih_c = (21'(div_rem_q[7:0]) * 21'(unit_q)) + {9'b0, extra_q};

	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);

	cdsat_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_TRACKS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(n_q[AW-1:0]),
		.wdata(wentry),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fph_q <= FPH_RESET;
			unit_q <= UNIT_RESET;
			subq_on_q <= 1'b0;
			n_q <= '0;
			idx_q <= '0;
			lc_q <= '0;
			sc_q <= '0;
			total_q <= '0;
			pos_q <= '0;
			ch_q <= '0;
			cv_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FPH: fph_q <= cfg_data[7:0];
					CFG_UNIT: unit_q <= cfg_data;
					CFG_SUBQ: subq_on_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						st_q <= ST_OK;
						len_q <= '0;
						zf_q <= 1'b0;
						sw_q <= 1'b0;
						hunk_q <= '0;
						bih_q <= '0;
						fetch_q <= 1'b0;
						unique case (mode_t'(in_data.mode))
							MODE_LOAD: begin
								if (in_data.first_track) begin
									n_q <= '0;
									lc_q <= '0;
									sc_q <= '0;
									total_q <= '0;
									pos_q <= '0;
									ch_q <= '0;
									cv_q <= 1'b0;
								end
								state_q <= S_LOAD_MUL;
							end
							MODE_SEEK: begin
								pos_q <= in_data.seek_offset;
								state_q <= S_DONE;
							end
							MODE_READ: state_q <= S_READ_CHK;
							default: state_q <= S_SUB_CHK;
						endcase
					end
				end
				S_LOAD_MUL: begin
					ts_s1 <= ts_c;
					next_s1 <= next_c;
					snext_s1 <= snext_c;
					prodv_s1 <= prodv_c;
					prodt_s1 <= prodt_c;
					full_s1 <= (32'(n_q) >= MAX_TRACKS);
					state_q <= S_LOAD_FIN;
				end
				S_LOAD_FIN: begin
					if (load_ok) begin
						lc_q <= next_s1[23:0];
						sc_q <= snext_s1[23:0];
						total_q <= tot_c[39:0];
						n_q <= n_q + 1'b1;
						last_kind_q <= in_q.track_kind;
						last_ts_q <= ts_s1[23:0];
						last_vs_q <= vs_c[39:0];
					end else begin
						st_q <= ST_FULL;
					end
					state_q <= S_DONE;
				end
				S_READ_CHK: begin
					idx_q <= '0;
					if (in_q.bytes_wanted == 16'd0) begin
						state_q <= S_DONE;
					end else if (pos_q >= total_q) begin
						st_q <= ST_END;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SUB_CHK: begin
					idx_q <= '0;
					if (!subq_on_q) begin
						st_q <= ST_GAP;
						state_q <= S_DONE;
					end else if (n_q == '0) begin
						st_q <= ST_END;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CMP;
				S_SCAN_CMP: begin
					if ((idx_q != '0) && hit) begin
						vend_q <= bound_rd;
						state_q <= S_MATCH;
					end else begin
						prev_q <= cur;
						idx_q <= idx_q + 1'b1;
						state_q <= ((idx_q + 1'b1) == n_q) ? S_SCAN_LAST : S_SCAN_RD;
					end
				end
				S_SCAN_LAST: begin
					if (hit) begin
						vend_q <= bound_rd;
						state_q <= S_MATCH;
					end else begin
						st_q <= ST_END;
						state_q <= S_DONE;
					end
				end
				S_MATCH: begin
					div_rem_q <= '0;
					div_cnt_q <= '0;
					if (in_q.mode == MODE_READ) begin
						div_q <= rel_c;
						div_den_q <= ds_c;
						state_q <= S_DIV_A;
					end else if (sfidx_c >= {5'b0, prev_q.frames}) begin
						st_q <= ST_GAP;
						state_q <= S_DONE;
					end else begin
						div_q <= {15'b0, sf_sub_c};
						div_den_q <= {4'b0, fph_eff};
						extra_q <= SECTOR_AREA;
						len_q <= {4'b0, SUBCODE_BYTES};
						state_q <= S_DIV_B;
					end
				end
				S_DIV_A, S_DIV_B: begin
					div_q <= {div_q[DIV_BITS-2:0], div_ge};
					div_rem_q <= div_ge ? 12'(div_t - {1'b0, div_den_q}) : div_t[11:0];
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(DIV_BITS - 1)) begin
						state_q <= (state_q == S_DIV_A) ? S_SEG : S_LOC;
					end
				end
				S_SEG: begin
					len_q <= len_c;
					pos_q <= pos_q + {24'b0, len_c};
					if (div_q >= {21'b0, prev_q.frames}) begin
						zf_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						extra_q <= div_rem_q;
						sw_q <= (prev_q.kind == KIND_AUDIO);
						div_q <= {15'b0, sf_rd_c};
						div_rem_q <= '0;
						div_den_q <= {4'b0, fph_eff};
						div_cnt_q <= '0;
						state_q <= S_DIV_B;
					end
				end
				S_LOC: begin
					hunk_q <= hunk_c;
					bih_q <= bih_c[19:0];
					fetch_q <= !cv_q || (hunk_c != ch_q);
					ch_q <= hunk_c;
					cv_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						out_q.status <= st_q;
						out_q.hunk_index <= (st_q == ST_OK) ? hunk_q : '0;
						out_q.byte_in_hunk <= (st_q == ST_OK) ? bih_q : '0;
						out_q.fetch_hunk <= (st_q == ST_OK) && fetch_q;
						out_q.segment_bytes <= (st_q == ST_OK) ? len_q[11:0] : '0;
						out_q.zero_fill <= (st_q == ST_OK) && zf_q;
						out_q.swap_bytes <= (st_q == ST_OK) && sw_q;
						out_q.position <= pos_q;
						out_q.image_size <= total_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/cdsat_checker.sv -----
// Port-level checks for the CD image sector address translator, bound to the top level.
// Depends on cdsat_pkg and cd_image_sector_address_translator.
module cdsat_checker
	import cdsat_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("response changed while stalled");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> (out_data.hunk_index == '0)
		&& (out_data.segment_bytes == '0) && !out_data.fetch_hunk && !out_data.zero_fill)
		else $error("failed request carries segment fields");

	a_gap_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_fill |-> (out_data.hunk_index == '0)
		&& !out_data.fetch_hunk && !out_data.swap_bytes && (out_data.byte_in_hunk == '0))
		else $error("zero-filled segment carries hunk fields");
endmodule

bind cd_image_sector_address_translator cdsat_checker u_cdsat_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the CD image sector address translator.
// Depends on cdsat_pkg and the block's RTL; it predicts every response and checks it.
`timescale 1ns / 100ps

module testbench;
	import cdsat_pkg::*;

	localparam int TRACK_CAP = 99;
	localparam int DRAIN_CYCLES = 320;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	cd_image_sector_address_translator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Translator state as the testbench expects it.
	logic [7:0] hunk_frames;
	logic [11:0] frame_bytes;
	logic subq_enabled;
	logic [2:0] tk_kind [TRACK_CAP];
	longint unsigned tk_frames [TRACK_CAP];
	longint unsigned tk_start [TRACK_CAP];
	longint unsigned tk_store [TRACK_CAP];
	longint unsigned tk_vstart [TRACK_CAP];
	int unsigned n_tracks;
	longint unsigned logic_cur, store_cur, image_bytes, cur_pos;
	longint unsigned last_hunk;
	bit hunk_cached;

	rsp_t expected_rsp [$];
	longint unsigned cycle = 0;
	longint unsigned hold_until = 0;
	bit calm = 1'b0;
	int unsigned n_mismatch = 0;
	int unsigned n_checked = 0;
	int unsigned n_reads = 0, n_gaps = 0, n_subq = 0, n_full = 0;

	function automatic longint unsigned sector_bytes(logic [2:0] k);
		longint unsigned sizes [8] = '{2352, 2048, 2352, 2336, 2048, 2324, 2336, 2352};
		return sizes[k];
	endfunction

	function automatic void wipe_table();
		n_tracks = 0;
		logic_cur = 0;
		store_cur = 0;
		image_bytes = 0;
		cur_pos = 0;
		last_hunk = 0;
		hunk_cached = 1'b0;
	endfunction

	function automatic longint unsigned track_vend(int unsigned i);
		return (i + 1 < n_tracks) ? tk_vstart[i + 1] : image_bytes;
	endfunction

	function automatic logic [1:0] append_track(req_t r);
		longint unsigned frames, gap, ts, ds, nxt, snxt, vs, tot;
		int unsigned n;
		n = n_tracks;
		frames = 64'(r.frame_count);
		gap = 64'(r.pregap_frames);
		if (n >= TRACK_CAP)
			return ST_FULL;
		if (r.pregap_stored) begin
			if (gap > frames)
				gap = frames;
			ts = logic_cur;
			ds = ts + gap;
			nxt = ts + frames;
		end else begin
			ts = logic_cur + gap;
			ds = ts;
			nxt = ds + frames;
		end
		snxt = store_cur + ((frames + 3) & ~64'd3);
		vs = 0;
		if (n > 0)
			vs = tk_vstart[n - 1] + (ts - tk_start[n - 1]) * sector_bytes(tk_kind[n - 1]);
		tot = vs + frames * sector_bytes(r.track_kind);
		if (nxt > 64'hFF_FFFF || snxt > 64'hFF_FFFF || tot > 64'hFF_FFFF_FFFF)
			return ST_FULL;
		tk_kind[n] = r.track_kind;
		tk_frames[n] = frames;
		tk_start[n] = ts;
		tk_store[n] = store_cur;
		tk_vstart[n] = vs;
		logic_cur = nxt;
		store_cur = snxt;
		image_bytes = tot;
		n_tracks = n + 1;
		return ST_OK;
	endfunction

	function automatic void place_frame(longint unsigned sf, longint unsigned extra,
			inout rsp_t o);
		longint unsigned fph, hunk;
		fph = (hunk_frames == 0) ? 64'd1 : 64'(hunk_frames);
		hunk = (sf / fph) & 64'hFF_FFFF;
		o.hunk_index = hunk[23:0];
		o.byte_in_hunk = 20'((sf % fph) * frame_bytes + extra);
		o.fetch_hunk = !hunk_cached || hunk != last_hunk;
		last_hunk = hunk;
		hunk_cached = 1'b1;
	endfunction

	function automatic logic [1:0] read_segment(req_t r, inout rsp_t o);
		longint unsigned rel, fidx, rem, len, ds, vend;
		int unsigned i;
		if (r.bytes_wanted == 0)
			return ST_OK;
		if (cur_pos >= image_bytes)
			return ST_END;
		for (i = 0; i < n_tracks; i++)
			if (cur_pos >= tk_vstart[i] && cur_pos < track_vend(i))
				break;
		if (i >= n_tracks)
			return ST_END;
		vend = track_vend(i);
		ds = sector_bytes(tk_kind[i]);
		rel = cur_pos - tk_vstart[i];
		fidx = rel / ds;
		rem = rel % ds;
		len = 64'(r.bytes_wanted);
		if (len > ds - rem)
			len = ds - rem;
		if (len > vend - cur_pos)
			len = vend - cur_pos;
		if (fidx >= tk_frames[i]) begin
			o.zero_fill = 1'b1;
		end else begin
			place_frame(tk_store[i] + fidx, rem, o);
			o.swap_bytes = (tk_kind[i] == KIND_AUDIO);
		end
		o.segment_bytes = len[11:0];
		cur_pos = cur_pos + len;
		return ST_OK;
	endfunction

	function automatic logic [1:0] locate_subcode(req_t r, inout rsp_t o);
		longint unsigned stop;
		int unsigned i;
		if (!subq_enabled)
			return ST_GAP;
		for (i = 0; i < n_tracks; i++) begin
			stop = (i + 1 < n_tracks) ? tk_start[i + 1] : tk_start[i] + tk_frames[i];
			if (r.lba >= tk_start[i] && r.lba < stop)
				break;
		end
		if (i >= n_tracks)
			return ST_END;
		if (r.lba - tk_start[i] >= tk_frames[i])
			return ST_GAP;
		place_frame(tk_store[i] + 64'(r.lba) - tk_start[i], 64'(SECTOR_AREA), o);
		o.segment_bytes = SUBCODE_BYTES;
		return ST_OK;
	endfunction

	function automatic rsp_t translate(req_t r);
		rsp_t o;
		logic [1:0] st;
		o = '0;
		st = ST_OK;
		case (mode_t'(r.mode))
			MODE_LOAD: begin
				if (r.first_track)
					wipe_table();
				st = append_track(r);
			end
			MODE_SEEK: cur_pos = 64'(r.seek_offset);
			MODE_READ: st = read_segment(r, o);
			default: st = locate_subcode(r, o);
		endcase
		if (st != ST_OK)
			o = '0;
		o.status = st;
		o.position = cur_pos[39:0];
		o.image_size = image_bytes[39:0];
		return o;
	endfunction

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycle);
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic check_field(string name, logic [39:0] got, logic [39:0] want, inout bit bad);
		if (got !== want) begin
			bad = 1'b1;
			if (n_mismatch < 10)
				$display("Mismatch in %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		rsp_t e;
		bit bad;
		out_ready <= (cycle >= hold_until) && (calm || $urandom_range(99) >= 17);
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsp.size() == 0) begin
				if (n_mismatch < 10)
					$display("Response with no request waiting: %p", out_data);
				n_mismatch++;
			end else begin
				e = expected_rsp.pop_front();
				bad = 1'b0;
				check_field("status", 40'(out_data.status), 40'(e.status), bad);
				check_field("hunk_index", 40'(out_data.hunk_index), 40'(e.hunk_index), bad);
				check_field("byte_in_hunk", 40'(out_data.byte_in_hunk),
					40'(e.byte_in_hunk), bad);
				check_field("segment_bytes", 40'(out_data.segment_bytes),
					40'(e.segment_bytes), bad);
				check_field("zero_fill", 40'(out_data.zero_fill), 40'(e.zero_fill), bad);
				check_field("swap_bytes", 40'(out_data.swap_bytes), 40'(e.swap_bytes), bad);
				check_field("fetch_hunk", 40'(out_data.fetch_hunk), 40'(e.fetch_hunk), bad);
				check_field("position", out_data.position, e.position, bad);
				check_field("image_size", out_data.image_size, e.image_size, bad);
				if (bad)
					n_mismatch++;
				n_checked++;
			end
		end
	end

	function automatic req_t noise_req();
		req_t r;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		return r;
	endfunction

	function automatic req_t load_req(bit first, logic [2:0] kind, int unsigned frames,
			int unsigned gap, bit stored);
		req_t r;
		r = noise_req();
		r.mode = MODE_LOAD;
		r.first_track = first;
		r.track_kind = kind;
		r.frame_count = 19'(frames);
		r.pregap_frames = 16'(gap);
		r.pregap_stored = stored;
		return r;
	endfunction

	function automatic req_t seek_req(longint unsigned offs);
		req_t r;
		r = noise_req();
		r.mode = MODE_SEEK;
		r.seek_offset = offs[39:0];
		return r;
	endfunction

	function automatic req_t read_req(int unsigned want);
		req_t r;
		r = noise_req();
		r.mode = MODE_READ;
		r.bytes_wanted = 16'(want);
		return r;
	endfunction

	function automatic req_t subq_req(longint unsigned lba);
		req_t r;
		r = noise_req();
		r.mode = MODE_SUBQ;
		r.lba = lba[23:0];
		return r;
	endfunction

	task automatic send(req_t r);
		rsp_t e;
		bit taken;
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		e = translate(r);
		if (r.mode == MODE_READ && e.status == ST_OK && r.bytes_wanted != 0) begin
			n_reads++;
			if (e.zero_fill)
				n_gaps++;
		end
		if (r.mode == MODE_SUBQ && e.status == ST_OK)
			n_subq++;
		if (e.status == ST_FULL)
			n_full++;
		expected_rsp.push_back(e);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [11:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FPH: hunk_frames = value[7:0];
			CFG_UNIT: frame_bytes = value;
			default: subq_enabled = value[0];
		endcase
		@(posedge clk);
	endtask

	function automatic longint unsigned pick_below(longint unsigned lim);
		longint unsigned v;
		v = {$urandom, $urandom};
		return (lim == 0) ? 0 : v % lim;
	endfunction

	task automatic test_empty_table();
		send(read_req(16'hFFFF));
		send(subq_req(0));
		send(read_req(0));
		send(seek_req(64'hFF_FFFF_FFFF));
		send(read_req(1));
	endtask

	task automatic test_directed_tracks();
		write_reg(CFG_SUBQ, 12'd1);
		send(load_req(1'b1, KIND_AUDIO, 5, 9, 1'b1));
		send(load_req(1'b0, KIND_MODE1, 3, 2, 1'b0));
		send(load_req(1'b0, KIND_MODE1_RAW, 0, 0, 1'b0));
		for (int k = KIND_MODE2; k <= KIND_MODE2_RAW; k++)
			send(load_req(1'b0, 3'(k), 2 + k, k, k[0]));
		send(seek_req(0));
		send(read_req(16'hFFFF));
		send(read_req(2352));
		send(read_req(1));
		send(seek_req(5 * 2352));
		send(read_req(100));
		send(subq_req(0));
		send(subq_req(6));
		send(subq_req(64'hFF_FFFF));
		send(seek_req(image_bytes - 1));
		send(read_req(16'hFFFF));
		send(read_req(5));
		send(load_req(1'b1, KIND_MODE2_RAW, 19'h7FFFF, 16'hFFFF, 1'b0));
		for (int k = 0; k < 33; k++)
			send(load_req(1'b0, 3'($urandom), 19'h7FFFF, 16'hFFFF, 1'b1));
		send(seek_req(64'h80_0000_0000));
		send(read_req(7));
	endtask

	task automatic test_table_capacity();
		send(load_req(1'b1, KIND_FORM2, 1, 0, 1'b0));
		for (int k = 1; k < TRACK_CAP + 2; k++)
			send(load_req(1'b0, 3'($urandom), $urandom_range(0, 3), $urandom_range(0, 2),
				1'($urandom_range(1))));
		for (int k = 0; k < 10; k++) begin
			send(seek_req(pick_below(image_bytes)));
			send(read_req($urandom_range(1, 4000)));
			send(subq_req(pick_below(logic_cur + 2)));
		end
		send(load_req(1'b1, KIND_AUDIO, 4, 0, 1'b0));
	endtask

	task automatic random_block();
		int unsigned pick;
		send(load_req(1'b1, 3'($urandom), $urandom_range(0, 40), $urandom_range(0, 20),
			1'($urandom_range(1))));
		repeat ($urandom_range(0, 5))
			send(load_req(1'b0, 3'($urandom), $urandom_range(0, 40), $urandom_range(0, 20),
				1'($urandom_range(1))));
		repeat ($urandom_range(15, 30)) begin
			pick = $urandom_range(99);
			if (pick < 50)
				send(read_req(($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 3000)));
			else if (pick < 63)
				send(seek_req(pick_below(image_bytes + 3000)));
			else if (pick < 80)
				send(subq_req(pick_below(logic_cur + 6)));
			else if (pick < 88)
				send(read_req(0));
			else
				send(noise_req());
		end
	endtask

	task automatic test_random_phases();
		logic [7:0] fph_set [7] = '{8'd8, 8'd1, 8'd255, 8'd0, 8'd3, 8'd16, 8'd7};
		logic [11:0] unit_set [7] = '{12'd2448, 12'd2352, 12'd2400, 12'd2448, 12'd2352,
			12'd4095, 12'd2447};
		for (int p = 0; p < 7; p++) begin
			write_reg(CFG_FPH, fph_set[p]);
			write_reg(CFG_UNIT, unit_set[p]);
			write_reg(CFG_SUBQ, 12'(p % 3 != 1));
			calm = (p == 2);
			repeat (4) random_block();
		end
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		send(load_req(1'b1, KIND_AUDIO, 30, 0, 1'b0));
		hold_until = cycle + 600;
		repeat (12)
			send(read_req($urandom_range(1, 3000)));
		drain();
		repeat (6)
			send(read_req($urandom_range(1, 3000)));
	endtask

	initial begin
		hunk_frames = FPH_RESET;
		frame_bytes = UNIT_RESET;
		subq_enabled = 1'b0;
		wipe_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_tracks();
		test_table_capacity();
		test_random_phases();
		test_backpressure();
		drain();
		$display("Checked %0d responses: %0d data segments, %0d zero-filled gaps,", n_checked,
			n_reads, n_gaps);
		$display("%0d subcode lookups and %0d table-full answers.", n_subq, n_full);
		if (n_mismatch == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatching responses.", n_mismatch);
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
